FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They are empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MACA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define MACA_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MACA_ASSERT(lbl, clk, rstn, prop)
`define MACA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: hdl/maca_pkg.sv
// ---------------------------------------------------------------------------
// maca_pkg
// Types and constants shared by the cluster assignment block and its cells.
// ---------------------------------------------------------------------------
`default_nettype none
package maca_pkg;

    typedef enum logic [1:0] {
        CMD_CENTRE     = 2'd0,
        CMD_CLASSIFIER = 2'd1,
        CMD_POINT      = 2'd2,
        CMD_NONE       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_HINGE_WEIGHT = 2'd0,
        CFG_DIST_WEIGHT  = 2'd1,
        CFG_MARGIN       = 2'd2,
        CFG_CLUSTERS     = 2'd3
    } t_cfg_idx;

    localparam logic [47:0] LOSS_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         cluster_index;
        logic [3:0]         dim_index;
        logic signed [15:0] value;
        logic               label;
        logic               last_element;
    } t_in;

    typedef struct packed {
        logic [3:0]  best_cluster;
        logic        predicted_label;
        logic [47:0] best_loss;
    } t_out;

    // Coordinate moving down the chain.
    typedef struct packed {
        logic               vld;
        logic [3:0]         dim;
        logic signed [15:0] x;
    } t_tok;

    // Table write broadcast to all cells.
    typedef struct packed {
        logic               vld;
        logic               classifier;
        logic [3:0]         cluster;
        logic [3:0]         dim;
        logic signed [15:0] value;
    } t_wr;

    // Loss phase control broadcast to all cells.
    typedef struct packed {
        logic               clr;
        logic               hinge;
        logic               mul;
        logic [1:0]         part;
        logic               fin;
        logic               label;
        logic signed [15:0] margin;
        logic [16:0]        w_hinge;
        logic [15:0]        w_dist;
    } t_cell_ctl;

    // Running minimum moving down the chain.
    typedef struct packed {
        logic        vld;
        logic        have;
        logic [3:0]  idx;
        logic        pos;
        logic [47:0] loss;
    } t_best;

endpackage
`default_nettype wire

FILE: hdl/maca_cell.sv
// ---------------------------------------------------------------------------
// maca_cell
// One cluster: its table rows, accumulators, loss and the compare step.
// ---------------------------------------------------------------------------
`default_nettype none
module maca_cell import maca_pkg::*; #(
    parameter int MAX_DIM = 16,
    parameter int IDX     = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tok      i_tok,
    output t_tok      o_tok,
    input  t_wr       i_wr,
    input  t_cell_ctl i_ctl,
    input  logic      i_en,
    input  t_best     i_best,
    output t_best     o_best
);
    localparam int DAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [15:0] r_centre [MAX_DIM];
    logic signed [15:0] r_class  [MAX_DIM];

    t_tok               r_tok;
    logic               r_s1_vld, r_s2_vld;
    logic signed [15:0] r_c, r_e, r_x;
    logic signed [31:0] r_pdot;
    logic [31:0]        r_dsq;
    logic signed [47:0] r_dot;
    logic [47:0]        r_dist;
    logic [47:0]        r_h;
    logic [64:0]        r_hacc;
    logic [63:0]        r_dacc;
    logic [47:0]        r_loss;
    logic               r_pos;
    t_best              r_best;

    logic               wr_hit, rd_ok;
    logic signed [16:0] diff;
    logic signed [33:0] dsq_full;
    logic signed [48:0] dot_sum, t_hinge, sdot;
    logic [48:0]        dist_sum;
    logic [15:0]        h_part, d_part;
    logic [32:0]        p_h;
    logic [31:0]        p_d;
    logic [64:0]        sh_h;
    logic [63:0]        sh_d;
    logic [57:0]        loss_sum;
    logic               take;

    assign wr_hit = i_wr.vld && (32'(i_wr.cluster) == IDX) && (32'(i_wr.dim) < MAX_DIM);
    assign rd_ok  = i_tok.vld && (32'(i_tok.dim) < MAX_DIM);

    always_ff @(posedge i_clk) begin
        if (wr_hit && i_wr.classifier) begin
            r_class[DAW'(i_wr.dim)] <= i_wr.value;
        end
        if (wr_hit && !i_wr.classifier) begin
            r_centre[DAW'(i_wr.dim)] <= i_wr.value;
        end
        r_c <= r_centre[DAW'(i_tok.dim)];
        r_e <= r_class[DAW'(i_tok.dim)];
        r_x <= i_tok.x;
    end

    assign diff     = 17'(r_x) - 17'(r_c);
    assign dsq_full = diff * diff;
    assign dot_sum  = 49'(r_dot) + 49'(r_pdot);
    assign dist_sum = 49'(r_dist) + 49'(r_dsq);

    always_ff @(posedge i_clk) begin
        r_pdot <= r_e * r_x;
        r_dsq  <= dsq_full[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_dot    <= '0;
            r_dist   <= '0;
        end else begin
            r_tok    <= i_tok;
            r_s1_vld <= rd_ok;
            r_s2_vld <= r_s1_vld;
            if (i_ctl.clr) begin
                r_dot  <= '0;
                r_dist <= '0;
            end else if (r_s2_vld) begin
                // Saturate to the signed and unsigned 48-bit ranges.
                if (dot_sum[48] != dot_sum[47]) begin
                    r_dot <= dot_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                end else begin
                    r_dot <= dot_sum[47:0];
                end
                r_dist <= dist_sum[48] ? LOSS_MAX : dist_sum[47:0];
            end
        end
    end

    assign o_tok = r_tok;

    assign sdot    = i_ctl.label ? 49'(r_dot) : -49'(r_dot);
    assign t_hinge = 49'($signed({i_ctl.margin, 8'b0})) - sdot;

    always_comb begin
        case (i_ctl.part)
            2'd0:    begin h_part = r_h[15:0];  d_part = r_dist[15:0];  end
            2'd1:    begin h_part = r_h[31:16]; d_part = r_dist[31:16]; end
            default: begin h_part = r_h[47:32]; d_part = r_dist[47:32]; end
        endcase
    end

    assign p_h = h_part * i_ctl.w_hinge;
    assign p_d = d_part * i_ctl.w_dist;

    always_comb begin
        case (i_ctl.part)
            2'd0:    begin sh_h = 65'(p_h);         sh_d = 64'(p_d);         end
            2'd1:    begin sh_h = 65'(p_h) << 16;   sh_d = 64'(p_d) << 16;   end
            default: begin sh_h = 65'(p_h) << 32;   sh_d = 64'(p_d) << 32;   end
        endcase
    end

    assign loss_sum = 58'(r_hacc[64:8]) + 58'(r_dacc[63:8]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.hinge) begin
            r_h <= (!t_hinge[48] && (t_hinge != '0)) ? t_hinge[47:0] : '0;
        end
        if (i_ctl.mul) begin
            r_hacc <= ((i_ctl.part == 2'd0) ? 65'd0 : r_hacc) + sh_h;
            r_dacc <= ((i_ctl.part == 2'd0) ? 64'd0 : r_dacc) + sh_d;
        end
        if (i_ctl.fin) begin
            r_loss <= (loss_sum[57:48] != '0) ? LOSS_MAX : loss_sum[47:0];
            r_pos  <= !r_dot[47] && (r_dot != '0);
        end
    end

    // Strict less keeps the earlier cluster on a tie.
    assign take = i_en && (!i_best.have || (r_loss < i_best.loss));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (i_best.vld && take) begin
            r_best <= '{vld: 1'b1, have: 1'b1, idx: 4'(IDX), pos: r_pos, loss: r_loss};
        end else begin
            r_best <= i_best;
        end
    end

    assign o_best = r_best;

endmodule
`default_nettype wire

FILE: hdl/margin_aware_cluster_assign.sv
// ---------------------------------------------------------------------------
// margin_aware_cluster_assign
// Cluster choice by combined hinge and distortion loss over a chain of cells.
// ---------------------------------------------------------------------------
// Table writes never raise busy. A point coordinate walks the chain of
// MAX_CLUSTERS cells, one cell per cycle, and busy stays high meanwhile. On
// the last coordinate the loss phase follows: a hinge step, partial products
// for the low, middle and high slices, a sum step and a compare walk down the
// chain, after which the result is shown with o_strobe for one cycle.
// The receiver cannot stall, so the result must be captured in that cycle.
`default_nettype none
`include "assert_macros.svh"
module margin_aware_cluster_assign import maca_pkg::*; #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIM      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in         i_data,
    output logic        o_strobe,
    output t_out        o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_CLUSTERS + 3) + 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FEED  = 6'b000010,
        ST_HINGE = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_CMP   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [15:0]        r_hw, r_dw;
    logic signed [15:0] r_margin;
    logic [4:0]         r_ciu;
    t_tok               r_head;
    logic               r_label, r_last;

    logic               accept;
    t_wr                wr;
    t_cell_ctl          ctl;
    t_best              best_start;
    logic [MAX_CLUSTERS-1:0] en;
    t_tok               tok  [MAX_CLUSTERS+1];
    t_best              bst  [MAX_CLUSTERS+1];

    assign o_busy      = (r_state != ST_IDLE);
    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw     <= 16'd256;
            r_dw     <= 16'd256;
            r_margin <= 16'sd256;
            r_ciu    <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HINGE_WEIGHT: r_hw     <= i_cfg_data;
                CFG_DIST_WEIGHT:  r_dw     <= i_cfg_data;
                CFG_MARGIN:       r_margin <= i_cfg_data;
                CFG_CLUSTERS:     r_ciu    <= i_cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        wr.vld        = accept && ((i_data.command == CMD_CENTRE) ||
                                   (i_data.command == CMD_CLASSIFIER));
        wr.classifier = (i_data.command == CMD_CLASSIFIER);
        wr.cluster    = i_data.cluster_index;
        wr.dim        = i_data.dim_index;
        wr.value      = i_data.value;
    end

    // Cluster zero always competes; larger counts are cut by the chain length.
    always_comb begin
        for (int k = 0; k < MAX_CLUSTERS; k++) begin
            en[k] = (k == 0) || (32'(r_ciu) > k);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept && (i_data.command == CMD_POINT)) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                if (r_cnt == CW'(MAX_CLUSTERS + 2)) begin
                    n_state = r_last ? ST_HINGE : ST_IDLE;
                end
            end
            ST_HINGE: begin
                n_state = ST_MUL;
                n_cnt   = '0;
            end
            ST_MUL: begin
                if (r_cnt == CW'(2)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_CMP;
                n_cnt   = '0;
            end
            ST_CMP: begin
                if (bst[MAX_CLUSTERS].vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_head  <= '{vld: accept && (i_data.command == CMD_POINT),
                         dim: i_data.dim_index, x: i_data.value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= 1'b0;
            r_label <= 1'b0;
        end else if (accept && (i_data.command == CMD_POINT)) begin
            r_last  <= i_data.last_element;
            r_label <= i_data.label;
        end
    end

    always_comb begin
        ctl.clr     = bst[MAX_CLUSTERS].vld;
        ctl.hinge   = (r_state == ST_HINGE);
        ctl.mul     = (r_state == ST_MUL);
        ctl.part    = r_cnt[1:0];
        ctl.fin     = (r_state == ST_FIN);
        ctl.label   = r_label;
        ctl.margin  = r_margin;
        ctl.w_hinge = {r_hw, 1'b0};
        ctl.w_dist  = r_dw;
    end

    // The compare walk starts once every cell holds its finished loss.
    assign best_start = '{vld: (r_state == ST_CMP) && (r_cnt == '0), have: 1'b0,
                          idx: 4'd0, pos: 1'b0, loss: '0};

    assign tok[0] = r_head;
    assign bst[0] = best_start;

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        maca_cell #(
            .MAX_DIM (MAX_DIM),
            .IDX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .i_wr    (wr),
            .i_ctl   (ctl),
            .i_en    (en[g]),
            .i_best  (bst[g]),
            .o_best  (bst[g+1])
        );
    end

    assign o_strobe                 = bst[MAX_CLUSTERS].vld;
    assign o_result.best_cluster    = bst[MAX_CLUSTERS].idx;
    assign o_result.predicted_label = bst[MAX_CLUSTERS].pos;
    assign o_result.best_loss       = bst[MAX_CLUSTERS].loss;

    `MACA_ASSERT(a_strobe_in_cmp, i_clk, i_rst_n, o_strobe |-> (r_state == ST_CMP))
    `MACA_ASSERT(a_idle_after_strobe, i_clk, i_rst_n, o_strobe |=> (r_state == ST_IDLE))
    `MACA_ASSERT(a_strobe_needs_last, i_clk, i_rst_n, o_strobe |-> r_last)
    `MACA_NEVER(a_hinge_from_feed, i_clk, i_rst_n,
        (r_state == ST_HINGE) && ($past(r_state) != ST_FEED))

endmodule
`default_nettype wire
